// ----- hw/rtl/jpt_pkg.sv -----
`default_nettype none
package jpt_pkg;

    localparam logic [7:0] CLS_NONE  = 8'h00;
    localparam logic [7:0] CLS_DIGIT = 8'hAA;
    localparam logic [7:0] CLS_ALPHA = 8'hEE;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;

    localparam logic [2:0] MODE_ROOT     = 3'd0;
    localparam logic [2:0] MODE_SEG      = 3'd1;
    localparam logic [2:0] MODE_DOT      = 3'd2;
    localparam logic [2:0] MODE_NAME     = 3'd3;
    localparam logic [2:0] MODE_BRACKET  = 3'd4;
    localparam logic [2:0] MODE_INDEX    = 3'd5;
    localparam logic [2:0] MODE_REJECTED = 3'd6;

    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_path;
    } t_in;

    typedef struct packed {
        logic        root_seen;
        logic        name_char_valid;
        logic [7:0]  name_char;
        logic        name_done;
        logic        index_done;
        logic [31:0] index_value;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] accum;
    } t_lex_state;

    function automatic logic [7:0] char_class(input logic [7:0] c);
        logic [7:0] cls;
        cls = CLS_NONE;
        if (c inside {[8'h30:8'h39]}) begin
            cls = CLS_DIGIT;
        end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, 8'h2D}) begin
            cls = CLS_ALPHA;
        end
        return cls;
    endfunction

    function automatic logic [2:0] segment_start(input logic [7:0] c);
        logic [2:0] m;
        m = MODE_REJECTED;
        if (c == CH_DOT) begin
            m = MODE_DOT;
        end else if (c == CH_LBRACK) begin
            m = MODE_BRACKET;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/json_path_tokenizer.sv -----
// Path expression tokenizer: one character or end-of-path mark per transfer in, exactly one
// result per transfer out, in order. Items pass an input register, combinational lexing against
// the parse state (mode and a 32-bit index accumulator with a times-ten add), and a result
// register, so one item is taken every cycle while the output side keeps up. Back-pressure on
// the output stalls the input register, and the input side then stalls in turn. Status is 0
// while running or after a syntax error, 1 or 2 on the end-of-path item, after which the
// parse state returns to its reset value.
`default_nettype none
module json_path_tokenizer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire jpt_pkg::t_in    i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output jpt_pkg::t_out        o_out_data
);

    logic                r_in_vld;
    jpt_pkg::t_in        r_in;
    logic                r_out_vld;
    jpt_pkg::t_out       r_out;
    jpt_pkg::t_lex_state r_state;

    jpt_pkg::t_lex_state n_state;
    jpt_pkg::t_out       n_out;
    logic                adv;

    assign adv         = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    jpt_lex u_lex (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_state.mode  <= jpt_pkg::MODE_ROOT;
            r_state.accum <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.end_of_path |=> r_state.mode == jpt_pkg::MODE_ROOT && r_state.accum == '0)
        else $error("parse state not cleared after end of path");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_in.end_of_path |=> r_out.status == jpt_pkg::ST_RUN)
        else $error("status reported on a character item");

    a_index_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.index_done |->
            !o_out_data.name_char_valid && !o_out_data.root_seen && !o_out_data.name_done)
        else $error("index completion mixed with other tokens");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready |=> r_out_vld && $stable(r_state))
        else $error("parse state moved while result stalled");

endmodule
`default_nettype wire

// ----- hw/rtl/jpt_lex.sv -----
`default_nettype none
module jpt_lex (
    input  wire jpt_pkg::t_lex_state i_state,
    input  wire jpt_pkg::t_in        i_item,
    output jpt_pkg::t_lex_state      o_state,
    output jpt_pkg::t_out            o_result
);

    logic [7:0]  cls;
    logic [31:0] digit;
    logic [31:0] times_ten;

    assign cls       = jpt_pkg::char_class(i_item.ch);
    assign digit     = {28'd0, i_item.ch[3:0]};
    assign times_ten = {i_state.accum[28:0], 3'b000} + {i_state.accum[30:0], 1'b0};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_item.end_of_path) begin
            if (i_state.mode == jpt_pkg::MODE_SEG) begin
                o_result.status = jpt_pkg::ST_ACCEPT;
            end else if (i_state.mode == jpt_pkg::MODE_NAME) begin
                o_result.name_done = 1'b1;
                o_result.status    = jpt_pkg::ST_ACCEPT;
            end else begin
                o_result.status = jpt_pkg::ST_REJECT;
            end
            o_state.mode  = jpt_pkg::MODE_ROOT;
            o_state.accum = '0;
        end else begin
            case (i_state.mode)
                jpt_pkg::MODE_ROOT: begin
                    if (i_item.ch == jpt_pkg::CH_DOLLAR) begin
                        o_result.root_seen = 1'b1;
                        o_state.mode       = jpt_pkg::MODE_SEG;
                    end else begin
                        o_state.mode = jpt_pkg::MODE_REJECTED;
                    end
                end
                jpt_pkg::MODE_SEG: begin
                    o_state.mode = jpt_pkg::segment_start(i_item.ch);
                end
                jpt_pkg::MODE_DOT: begin
                    if (cls != jpt_pkg::CLS_NONE) begin
                        o_result.name_char_valid = 1'b1;
                        o_result.name_char       = i_item.ch;
                        o_state.mode             = jpt_pkg::MODE_NAME;
                    end else begin
                        o_state.mode = jpt_pkg::MODE_REJECTED;
                    end
                end
                jpt_pkg::MODE_NAME: begin
                    if (cls != jpt_pkg::CLS_NONE) begin
                        o_result.name_char_valid = 1'b1;
                        o_result.name_char       = i_item.ch;
                    end else begin
                        o_result.name_done = 1'b1;
                        o_state.mode       = jpt_pkg::segment_start(i_item.ch);
                    end
                end
                jpt_pkg::MODE_BRACKET: begin
                    if (cls == jpt_pkg::CLS_DIGIT) begin
                        o_state.accum = digit;
                        o_state.mode  = jpt_pkg::MODE_INDEX;
                    end else begin
                        o_state.mode = jpt_pkg::MODE_REJECTED;
                    end
                end
                jpt_pkg::MODE_INDEX: begin
                    if (cls == jpt_pkg::CLS_DIGIT) begin
                        o_state.accum = times_ten + digit;
                    end else if (i_item.ch == jpt_pkg::CH_RBRACK) begin
                        o_result.index_done  = 1'b1;
                        o_result.index_value = i_state.accum;
                        o_state.accum        = '0;
                        o_state.mode         = jpt_pkg::MODE_SEG;
                    end else begin
                        o_state.mode = jpt_pkg::MODE_REJECTED;
                    end
                end
                default: begin
                    o_state.mode = jpt_pkg::MODE_REJECTED;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/json_path_tokenizer_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module json_path_tokenizer_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    jpt_pkg::t_in  in_data = '0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    jpt_pkg::t_out out_data;

    logic [2:0]    lex_mode = jpt_pkg::MODE_ROOT;
    logic [31:0]   index_acc = '0;
    jpt_pkg::t_out pending_results[$];

    int sent_count = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    json_path_tokenizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [2:0] segment_mode(input logic [7:0] c);
        if (c == jpt_pkg::CH_DOT) begin
            return jpt_pkg::MODE_DOT;
        end
        if (c == jpt_pkg::CH_LBRACK) begin
            return jpt_pkg::MODE_BRACKET;
        end
        return jpt_pkg::MODE_REJECTED;
    endfunction

    // next token fields for one transfer, advancing the lexer state
    function automatic jpt_pkg::t_out predict_token(input jpt_pkg::t_in item);
        jpt_pkg::t_out r;
        logic is_digit;
        logic is_name;
        r = '0;
        is_digit = (item.ch >= "0") && (item.ch <= "9");
        is_name = is_digit || ((item.ch >= "A") && (item.ch <= "Z"))
            || ((item.ch >= "a") && (item.ch <= "z")) || (item.ch == "_") || (item.ch == "-");
        if (item.end_of_path) begin
            case (lex_mode)
                jpt_pkg::MODE_SEG: begin
                    r.status = jpt_pkg::ST_ACCEPT;
                end
                jpt_pkg::MODE_NAME: begin
                    r.name_done = 1'b1;
                    r.status = jpt_pkg::ST_ACCEPT;
                end
                default: begin
                    r.status = jpt_pkg::ST_REJECT;
                end
            endcase
            lex_mode = jpt_pkg::MODE_ROOT;
            index_acc = '0;
        end else begin
            case (lex_mode)
                jpt_pkg::MODE_ROOT: begin
                    if (item.ch == jpt_pkg::CH_DOLLAR) begin
                        r.root_seen = 1'b1;
                        lex_mode = jpt_pkg::MODE_SEG;
                    end else begin
                        lex_mode = jpt_pkg::MODE_REJECTED;
                    end
                end
                jpt_pkg::MODE_SEG: begin
                    lex_mode = segment_mode(item.ch);
                end
                jpt_pkg::MODE_DOT: begin
                    if (is_name) begin
                        r.name_char_valid = 1'b1;
                        r.name_char = item.ch;
                        lex_mode = jpt_pkg::MODE_NAME;
                    end else begin
                        lex_mode = jpt_pkg::MODE_REJECTED;
                    end
                end
                jpt_pkg::MODE_NAME: begin
                    if (is_name) begin
                        r.name_char_valid = 1'b1;
                        r.name_char = item.ch;
                    end else begin
                        r.name_done = 1'b1;
                        lex_mode = segment_mode(item.ch);
                    end
                end
                jpt_pkg::MODE_BRACKET: begin
                    if (is_digit) begin
                        index_acc = 32'(item.ch - "0");
                        lex_mode = jpt_pkg::MODE_INDEX;
                    end else begin
                        lex_mode = jpt_pkg::MODE_REJECTED;
                    end
                end
                jpt_pkg::MODE_INDEX: begin
                    if (is_digit) begin
                        index_acc = index_acc * 32'd10 + 32'(item.ch - "0");
                    end else if (item.ch == jpt_pkg::CH_RBRACK) begin
                        r.index_done = 1'b1;
                        r.index_value = index_acc;
                        index_acc = '0;
                        lex_mode = jpt_pkg::MODE_SEG;
                    end else begin
                        lex_mode = jpt_pkg::MODE_REJECTED;
                    end
                end
                default: begin
                    lex_mode = jpt_pkg::MODE_REJECTED;
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        mismatches++;
    endtask

    // result checking and receiver stalls
    always @(posedge clk) begin
        jpt_pkg::t_out want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %h", $time,
                             out_data);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_data.root_seen !== want.root_seen)
                        report_mismatch("root_seen", want.root_seen, out_data.root_seen);
                    if (out_data.name_char_valid !== want.name_char_valid)
                        report_mismatch("name_char_valid", want.name_char_valid,
                                        out_data.name_char_valid);
                    if (out_data.name_char !== want.name_char)
                        report_mismatch("name_char", want.name_char, out_data.name_char);
                    if (out_data.name_done !== want.name_done)
                        report_mismatch("name_done", want.name_done, out_data.name_done);
                    if (out_data.index_done !== want.index_done)
                        report_mismatch("index_done", want.index_done, out_data.index_done);
                    if (out_data.index_value !== want.index_value)
                        report_mismatch("index_value", want.index_value, out_data.index_value);
                    if (out_data.status !== want.status)
                        report_mismatch("status", want.status, out_data.status);
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input jpt_pkg::t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        pending_results.push_back(predict_token(item));
        sent_count++;
    endtask

    function automatic jpt_pkg::t_in char_item(input logic [7:0] c);
        jpt_pkg::t_in item;
        item.ch = c;
        item.end_of_path = 1'b0;
        return item;
    endfunction

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(char_item(s[i]));
        end
    endtask

    task automatic send_end(input logic [7:0] c);
        jpt_pkg::t_in item;
        item.ch = c;
        item.end_of_path = 1'b1;
        send_item(item);
    endtask

    function automatic logic [7:0] rand_name_char();
        int pick;
        pick = $urandom_range(63);
        if (pick < 26) return 8'("A" + pick);
        if (pick < 52) return 8'("a" + pick - 26);
        if (pick < 62) return 8'("0" + pick - 52);
        if (pick == 62) return "_";
        return "-";
    endfunction

    task automatic send_random_path();
        jpt_pkg::t_in seq[$];
        jpt_pkg::t_in item;
        string max_index;
        int    nseg;
        int    n;
        int    pick;
        int    pos;
        max_index = "4294967295";
        pick = $urandom_range(99);
        if (pick < 6) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                item.ch = 8'($urandom_range(255));
                item.end_of_path = ($urandom_range(9) == 0);
                seq.push_back(item);
            end
        end else begin
            seq.push_back(char_item(jpt_pkg::CH_DOLLAR));
            nseg = $urandom_range(0, 4);
            repeat (nseg) begin
                if ($urandom_range(1) == 1) begin
                    seq.push_back(char_item(jpt_pkg::CH_DOT));
                    n = $urandom_range(1, 6);
                    repeat (n) seq.push_back(char_item(rand_name_char()));
                end else begin
                    seq.push_back(char_item(jpt_pkg::CH_LBRACK));
                    pick = $urandom_range(9);
                    if (pick == 0) begin
                        for (int i = 0; i < max_index.len(); i++) begin
                            seq.push_back(char_item(max_index[i]));
                        end
                    end else begin
                        n = (pick == 1) ? $urandom_range(10, 12) : $urandom_range(1, 3);
                        repeat (n) seq.push_back(char_item(8'("0" + $urandom_range(9))));
                    end
                    seq.push_back(char_item(jpt_pkg::CH_RBRACK));
                end
            end
            // broken sequences: cut short, one byte overwritten, or one byte inserted
            pick = $urandom_range(99);
            if (pick < 8) begin
                pos = $urandom_range(seq.size() - 1);
                while (seq.size() > pos) void'(seq.pop_back());
            end else if (pick < 16) begin
                pos = $urandom_range(seq.size() - 1);
                item = seq[pos];
                item.ch = 8'($urandom_range(255));
                seq[pos] = item;
            end else if (pick < 22) begin
                seq.insert($urandom_range(seq.size()), char_item(8'($urandom_range(255))));
            end
        end
        item.ch = 8'($urandom_range(255));
        item.end_of_path = 1'b1;
        seq.push_back(item);
        foreach (seq[i]) send_item(seq[i]);
    endtask

    task automatic test_end_cases();
        send_end(8'hFF);
        send_text("$.");
        send_end(8'h00);
        send_text("$[");
        send_end(8'h5A);
        send_text("$[7");
        send_end(8'hA5);
    endtask

    task automatic test_segments();
        send_text("$.Z-[9].z_0");
        send_end(8'h80);
    endtask

    task automatic test_rejections();
        send_text("$.a");
        send_item(char_item(8'h80));
        send_text("x");
        send_end(jpt_pkg::CH_DOLLAR);
        send_item(char_item(8'h00));
        send_end(8'h7F);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        send_text("$.pressure[123].x_y-z[42]");
        send_end(8'h00);
    endtask

    task automatic test_random_paths(input int send_pct, input int recv_pct, input int n_items);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            send_random_path();
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 37;
        recv_idle_pct = 52;
        test_end_cases();
        test_segments();
        test_rejections();
        test_backpressure();
        test_random_paths(37, 52, 600);
        test_random_paths(52, 37, 600);
        test_random_paths(0, 0, 600);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
